// ===== src/flvavc_pkg.sv =====
`default_nettype none

package flvavc_pkg;

  // Parser position inside the tag body
  typedef enum logic [3:0] {
    PH_TAG     = 4'd0,
    PH_PTYPE   = 4'd1,
    PH_CTS     = 4'd2,
    PH_CFG     = 4'd3,
    PH_SPSCNT  = 4'd4,
    PH_SETLEN  = 4'd5,
    PH_SETDATA = 4'd6,
    PH_PPSCNT  = 4'd7,
    PH_NALLEN  = 4'd8,
    PH_NALHEAD = 4'd9,
    PH_NALDATA = 4'd10,
    PH_SKIP    = 4'd11
  } ph_e;

  // Sequencer: idle, writing a start code into the store, replaying the store
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SC     = 2'd1,
    ST_REPLAY = 2'd2
  } st_e;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic        key;
    logic [15:0] idr;
    logic        ovf;
  } out_word_t;

  localparam logic [3:0]  CodecAvc    = 4'h7;
  localparam logic [3:0]  FrameCmd    = 4'h5;
  localparam logic [7:0]  PktSeqHdr   = 8'h00;
  localparam logic [7:0]  PktNalu     = 8'h01;
  localparam logic [4:0]  NalIdr      = 5'd5;
  localparam logic [1:0]  KindSps     = 2'd0;
  localparam logic [1:0]  KindNalu    = 2'd1;
  localparam logic [1:0]  KindPps     = 2'd2;
  localparam logic [15:0] IdrMax      = 16'hFFFF;
  // 00 00 00 01, first byte in the low lane
  localparam logic [31:0] StartCode   = 32'h0100_0000;
  localparam logic [7:0]  StartCodeLo = 8'h01;

endpackage

`default_nettype wire

// ===== src/flv_avc_to_annexb_converter_top.sv =====
// Channel | handshake             | payload
// --------+-----------------------+---------------------------------------------
// in      | in_valid_i/in_ready_o | in_byte_i, tag_end_i
// out     | out_valid_o/out_ready_i | out_bytes_o, out_count_o, out_last_o,
//         |                       | key_frame_o, idr_total_o, store_overflow_o
//
// One cycle per input byte in the common case; results leave through a 2-deep queue.
// A completed parameter-set length holds the input while the start code is
// written into the store through its single write port, one byte per cycle.
// An IDR NAL header replays the stored bytes, one store read per cycle unless stalled.
// Reset clears all control state; the store is not cleared, only written entries are read.
// A full output queue stalls the input and the replay.
`default_nettype none

module flv_avc_to_annexb_converter_top #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        tag_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [63:0] out_bytes_o,
  output logic      [3:0]  out_count_o,
  output logic             out_last_o,
  output logic             key_frame_o,
  output logic      [15:0] idr_total_o,
  output logic             store_overflow_o
);

  import flvavc_pkg::*;

  localparam int unsigned AddrW = $clog2(STORE_BYTES);
  localparam int unsigned LenW  = $clog2(STORE_BYTES + 1);
  localparam logic [LenW-1:0] StoreMax  = LenW'(STORE_BYTES);
  localparam logic [LenW:0]   StoreMaxX = (LenW+1)'(STORE_BYTES);

  // parser state
  ph_e             phase_q, phase_d;
  logic [2:0]      fbi_q, fbi_d;
  logic [31:0]     len_q, len_d;
  logic [31:0]     rem_q, rem_d;
  logic [4:0]      sets_q, sets_d;
  logic [1:0]      kind_q, kind_d;
  logic [LenW-1:0] store_len_q, store_len_d;
  logic [15:0]     idr_q, idr_d;
  logic            key_q, key_d;
  logic            ovf_q, ovf_d;

  // sequencer state
  st_e             st_q, st_d;
  logic [1:0]      sc_idx_q, sc_idx_d;
  logic [LenW-1:0] sc_base_q, sc_base_d;
  logic [LenW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic [2:0]      tail_q, tail_d;
  logic [3:0]      pk_cnt_q, pk_cnt_d;
  logic [63:0]     pk_data_q, pk_data_d;
  logic [7:0]      hdr_q, hdr_d;
  logic            end_q, end_d;

  // output queue
  out_word_t       fifo_q [2];
  logic [1:0]      fifo_cnt_q, fifo_cnt_d;
  logic            wptr_q, rptr_q;
  logic            push, pop;
  out_word_t       push_word;

  // store port
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  // parse helpers
  logic            acc;
  logic [15:0]     set_len;
  logic [31:0]     nal_len;
  logic [31:0]     rem_dec;
  logic [4:0]      sets_dec;
  ph_e             fin_phase;
  logic [LenW:0]   sl_plus4;
  logic [LenW:0]   sc_sum;
  logic [1:0]      kind_eff;
  logic            now_push, go_sc, go_rep;
  logic [63:0]     now_bytes;
  logic [3:0]      now_cnt;
  logic            now_last;

  // replay helpers
  logic            space, full, push_full, tail_mode, byte_avail, is_final, take, issue;
  logic            rep_push;
  logic [3:0]      cnt_eff;
  logic [7:0]      src_byte, tail_byte;
  logic [63:0]     ins;
  logic [63:0]     rep_bytes;
  logic [3:0]      rep_cnt;
  logic            rep_last;

  assign in_ready_o = (st_q == ST_IDLE) && (fifo_cnt_q != 2'd2);
  assign acc        = in_valid_i && in_ready_o;

  assign set_len   = {len_q[7:0], in_byte_i};
  assign nal_len   = {len_q[23:0], in_byte_i};
  assign rem_dec   = rem_q - 32'd1;
  assign sets_dec  = sets_q - 5'd1;
  assign fin_phase = (sets_dec != 5'd0) ? PH_SETLEN :
                     (kind_q == KindSps) ? PH_PPSCNT : PH_SKIP;
  assign sl_plus4  = {1'b0, store_len_q} + (LenW+1)'(4);
  assign sc_sum    = {1'b0, sc_base_q} + (LenW+1)'(sc_idx_q);
  assign kind_eff  = (phase_q == PH_PPSCNT) ? KindPps : kind_q;

  // Byte parser: runs once per accepted input byte
  always_comb begin
    phase_d     = phase_q;
    fbi_d       = fbi_q;
    len_d       = len_q;
    rem_d       = rem_q;
    sets_d      = sets_q;
    kind_d      = kind_q;
    store_len_d = store_len_q;
    idr_d       = idr_q;
    key_d       = key_q;
    ovf_d       = ovf_q;
    mem_we      = 1'b0;
    mem_waddr   = store_len_q[AddrW-1:0];
    mem_wdata   = in_byte_i;
    now_push    = 1'b0;
    now_bytes   = '0;
    now_cnt     = '0;
    now_last    = 1'b0;
    go_sc       = 1'b0;
    go_rep      = 1'b0;

    if (acc) begin
      unique case (phase_q)
        PH_TAG: begin
          if (in_byte_i[3:0] != CodecAvc || in_byte_i[7:4] == FrameCmd) begin
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_PTYPE;
          end
        end
        PH_PTYPE: begin
          if (in_byte_i == PktSeqHdr) begin
            kind_d      = KindSps;
            store_len_d = '0;
            ovf_d       = 1'b0;
            phase_d     = PH_CTS;
            fbi_d       = '0;
          end else if (in_byte_i == PktNalu) begin
            kind_d  = KindNalu;
            phase_d = PH_CTS;
            fbi_d   = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_CTS: begin
          if (fbi_q == 3'd2) begin
            fbi_d   = '0;
            len_d   = '0;
            phase_d = (kind_q == KindNalu) ? PH_NALLEN : PH_CFG;
          end else begin
            fbi_d = fbi_q + 3'd1;
          end
        end
        PH_CFG: begin
          if (fbi_q == 3'd4) begin
            fbi_d   = '0;
            phase_d = PH_SPSCNT;
          end else begin
            fbi_d = fbi_q + 3'd1;
          end
        end
        PH_SPSCNT, PH_PPSCNT: begin
          kind_d = kind_eff;
          sets_d = in_byte_i[4:0];
          fbi_d  = '0;
          if (in_byte_i[4:0] != 5'd0) begin
            phase_d = PH_SETLEN;
          end else begin
            phase_d = (kind_eff == KindSps) ? PH_PPSCNT : PH_SKIP;
          end
        end
        PH_SETLEN: begin
          len_d = {16'h0000, set_len};
          if (fbi_q == 3'd1) begin
            fbi_d = '0;
            go_sc = 1'b1;
            // start code fits partly or not at all: clip the length, flag it
            if (sl_plus4 > StoreMaxX) begin
              store_len_d = StoreMax;
              ovf_d       = 1'b1;
            end else begin
              store_len_d = sl_plus4[LenW-1:0];
            end
            rem_d = {16'h0000, set_len};
            if (set_len == 16'h0000) begin
              sets_d  = sets_dec;
              phase_d = fin_phase;
            end else begin
              phase_d = PH_SETDATA;
            end
          end else begin
            fbi_d = fbi_q + 3'd1;
          end
        end
        PH_SETDATA: begin
          if (store_len_q < StoreMax) begin
            mem_we      = 1'b1;
            store_len_d = store_len_q + LenW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          rem_d = rem_dec;
          if (rem_dec == 32'd0) begin
            sets_d  = sets_dec;
            fbi_d   = '0;
            phase_d = fin_phase;
          end
        end
        PH_NALLEN: begin
          len_d = nal_len;
          if (fbi_q == 3'd3) begin
            fbi_d = '0;
            rem_d = nal_len;
            len_d = '0;
            if (nal_len == 32'd0) begin
              key_d     = 1'b0;
              now_push  = 1'b1;
              now_bytes = {32'h0000_0000, StartCode};
              now_cnt   = 4'd4;
            end else begin
              phase_d = PH_NALHEAD;
            end
          end else begin
            fbi_d = fbi_q + 3'd1;
          end
        end
        PH_NALHEAD: begin
          key_d = (in_byte_i[4:0] == NalIdr);
          if (in_byte_i[4:0] == NalIdr) begin
            if (idr_q != IdrMax) begin
              idr_d = idr_q + 16'd1;
            end
          end
          if (in_byte_i[4:0] == NalIdr && store_len_q != '0) begin
            go_rep = 1'b1;
          end else begin
            now_push  = 1'b1;
            now_bytes = {24'h000000, in_byte_i, StartCode};
            now_cnt   = 4'd5;
          end
          rem_d   = rem_dec;
          phase_d = (rem_dec == 32'd0) ? PH_NALLEN : PH_NALDATA;
        end
        PH_NALDATA: begin
          now_push  = 1'b1;
          now_bytes = {56'h0, in_byte_i};
          now_cnt   = 4'd1;
          rem_d     = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_d = PH_NALLEN;
          end
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase

      if (tag_end_i) begin
        // bare end marker when the byte produced nothing
        if (!now_push && !go_rep) begin
          now_push = 1'b1;
        end
        now_last = 1'b1;
        phase_d  = PH_TAG;
        fbi_d    = '0;
        len_d    = '0;
        rem_d    = '0;
        sets_d   = '0;
      end
    end

    if (st_q == ST_SC) begin
      mem_we    = (sc_sum < StoreMaxX);
      mem_waddr = sc_sum[AddrW-1:0];
      mem_wdata = (sc_idx_q == 2'd3) ? StartCodeLo : 8'h00;
    end
  end

  // Replay datapath: store bytes, then 00 00 00 01 and the NAL header byte
  assign space      = (fifo_cnt_q != 2'd2);
  assign full       = (pk_cnt_q == 4'd8);
  assign push_full  = (st_q == ST_REPLAY) && full && space;
  assign cnt_eff    = push_full ? 4'd0 : pk_cnt_q;
  assign tail_mode  = !rd_vld_q && (rd_idx_q == store_len_q);
  assign byte_avail = rd_vld_q || tail_mode;
  assign tail_byte  = (tail_q == 3'd4) ? hdr_q :
                      (tail_q == 3'd3) ? StartCodeLo : 8'h00;
  assign src_byte   = rd_vld_q ? mem_rdata : tail_byte;
  assign is_final   = tail_mode && (tail_q == 3'd4);
  assign take       = (st_q == ST_REPLAY) && byte_avail && (!full || push_full) &&
                      (!is_final || (!full && space));
  assign issue      = (st_q == ST_REPLAY) && (rd_idx_q < store_len_q) &&
                      (!rd_vld_q || take);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (cnt_eff == 4'(i)) begin
        ins[8*i +: 8] = src_byte;
      end else begin
        ins[8*i +: 8] = push_full ? 8'h00 : pk_data_q[8*i +: 8];
      end
    end
  end

  assign rep_push  = push_full || (take && is_final);
  assign rep_bytes = push_full ? pk_data_q : ins;
  assign rep_cnt   = push_full ? 4'd8 : (cnt_eff + 4'd1);
  assign rep_last  = push_full ? 1'b0 : end_q;

  assign mem_re    = issue;
  assign mem_raddr = rd_idx_q[AddrW-1:0];

  // Sequencer next state
  always_comb begin
    st_d      = st_q;
    sc_idx_d  = sc_idx_q;
    sc_base_d = sc_base_q;
    rd_idx_d  = rd_idx_q;
    rd_vld_d  = rd_vld_q;
    tail_d    = tail_q;
    pk_cnt_d  = pk_cnt_q;
    pk_data_d = pk_data_q;
    hdr_d     = hdr_q;
    end_d     = end_q;

    unique case (st_q)
      ST_IDLE: begin
        if (go_sc) begin
          st_d      = ST_SC;
          sc_idx_d  = '0;
          sc_base_d = store_len_q;
        end else if (go_rep) begin
          st_d      = ST_REPLAY;
          rd_idx_d  = '0;
          rd_vld_d  = 1'b0;
          tail_d    = '0;
          pk_cnt_d  = '0;
          pk_data_d = '0;
          hdr_d     = in_byte_i;
          end_d     = tail_end_sel(tag_end_i);
        end
      end
      ST_SC: begin
        sc_idx_d = sc_idx_q + 2'd1;
        if (sc_idx_q == 2'd3) begin
          st_d = ST_IDLE;
        end
      end
      ST_REPLAY: begin
        if (issue) begin
          rd_idx_d = rd_idx_q + LenW'(1);
        end
        if (issue) begin
          rd_vld_d = 1'b1;
        end else if (take && rd_vld_q) begin
          rd_vld_d = 1'b0;
        end
        if (take && tail_mode) begin
          tail_d = tail_q + 3'd1;
        end
        if (take) begin
          pk_data_d = ins;
          pk_cnt_d  = cnt_eff + 4'd1;
        end else if (push_full) begin
          pk_data_d = '0;
          pk_cnt_d  = '0;
        end
        if (take && is_final) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  function automatic logic tail_end_sel(input logic e);
    return e;
  endfunction

  // Output queue
  assign push = now_push || rep_push;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    push_word.bytes = rep_push ? rep_bytes : now_bytes;
    push_word.cnt   = rep_push ? rep_cnt : now_cnt;
    push_word.last  = rep_push ? rep_last : now_last;
    push_word.key   = key_d;
    push_word.idr   = idr_d;
    push_word.ovf   = ovf_d;
    fifo_cnt_d      = fifo_cnt_q + {1'b0, push} - {1'b0, pop};
  end

  assign out_valid_o      = (fifo_cnt_q != 2'd0);
  assign out_bytes_o      = fifo_q[rptr_q].bytes;
  assign out_count_o      = fifo_q[rptr_q].cnt;
  assign out_last_o       = fifo_q[rptr_q].last;
  assign key_frame_o      = fifo_q[rptr_q].key;
  assign idr_total_o      = fifo_q[rptr_q].idr;
  assign store_overflow_o = fifo_q[rptr_q].ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TAG;
      fbi_q       <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      sets_q      <= '0;
      kind_q      <= KindSps;
      store_len_q <= '0;
      idr_q       <= '0;
      key_q       <= 1'b0;
      ovf_q       <= 1'b0;
      st_q        <= ST_IDLE;
      sc_idx_q    <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      tail_q      <= '0;
      pk_cnt_q    <= '0;
      end_q       <= 1'b0;
      fifo_cnt_q  <= '0;
      wptr_q      <= 1'b0;
      rptr_q      <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fbi_q       <= fbi_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      sets_q      <= sets_d;
      kind_q      <= kind_d;
      store_len_q <= store_len_d;
      idr_q       <= idr_d;
      key_q       <= key_d;
      ovf_q       <= ovf_d;
      st_q        <= st_d;
      sc_idx_q    <= sc_idx_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      tail_q      <= tail_d;
      pk_cnt_q    <= pk_cnt_d;
      end_q       <= end_d;
      fifo_cnt_q  <= fifo_cnt_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sc_base_q <= sc_base_d;
    pk_data_q <= pk_data_d;
    hdr_q     <= hdr_d;
    if (push) begin
      fifo_q[wptr_q] <= push_word;
    end
  end

  flvavc_ram #(
    .Width (8),
    .Depth (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q != 2'd3)
    else $error("output queue count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q != 2'd2 || pop))
    else $error("transfer into a full output queue");

  a_store_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_len_q <= StoreMax)
    else $error("store length beyond capacity");

  a_replay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_REPLAY |-> rd_idx_q <= store_len_q)
    else $error("replay read past stored sets");

  a_sc_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SC && sc_idx_q == 2'd3) |=> st_q == ST_IDLE)
    else $error("start code write did not finish in four cycles");

endmodule

`default_nettype wire

// ===== src/flvavc_ram.sv =====
`default_nettype none

module flvavc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
